// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion helpers shared by the encoder modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ----- hdl/b64e_pkg.sv -----
// ----------------------------------------------------------------------------
// b64e_pkg
// shared types, constants and alphabet lookup for the base64 encoder
// ----------------------------------------------------------------------------
`default_nettype none

package b64e_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CHAR_W  = 7;
    localparam int unsigned GROUP_W = 24;
    localparam int unsigned SLICE_W = 6;

    localparam logic [CHAR_W-1:0] PAD_CHAR = 7'h3D;

    // number of '=' characters closing a group
    typedef enum logic [1:0] {
        PAD_NONE = 2'd0,
        PAD_ONE  = 2'd1,
        PAD_TWO  = 2'd2
    } t_pad;

    typedef struct packed {
        logic [GROUP_W-1:0] bits;
        t_pad               pad;
        logic               fin;
    } t_group;

    // standard alphabet: A-Z a-z 0-9 + /
    function automatic logic [CHAR_W-1:0] b64_char(input logic [SLICE_W-1:0] v);
        logic [CHAR_W-1:0] c;
        logic [CHAR_W-1:0] v7;
        v7 = {1'b0, v};
        if (v < 6'd26) begin
            c = 7'h41 + v7;
        end else if (v < 6'd52) begin
            c = 7'h61 + v7 - 7'd26;
        end else if (v < 6'd62) begin
            c = 7'h30 + v7 - 7'd52;
        end else if (v == 6'd62) begin
            c = 7'h2B;
        end else begin
            c = 7'h2F;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/b64e_front.sv -----
// ----------------------------------------------------------------------------
// b64e_front
// accepts bytes, holds a partial group and hands full or final groups on
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module b64e_front (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    input  wire logic [7:0]             i_data_byte,
    input  wire logic                   i_last_byte,
    input  wire logic                   i_q_full,
    output logic                        o_full,
    output logic                        o_grp_push,
    output b64e_pkg::t_group            o_grp
);
    import b64e_pkg::*;

    logic [BYTE_W-1:0] r_held [2];
    logic [1:0]        r_fill;
    logic              accept;
    logic              complete;

    assign o_full     = i_q_full;
    assign accept     = i_push && !i_q_full;
    // a fill of three never arises; treated as two
    assign complete   = r_fill[1] || i_last_byte;
    assign o_grp_push = accept && complete;

    always_comb begin
        o_grp.fin = i_last_byte;
        if (r_fill[1]) begin
            o_grp.bits = {r_held[0], r_held[1], i_data_byte};
            o_grp.pad  = PAD_NONE;
        end else if (r_fill[0]) begin
            o_grp.bits = {r_held[0], i_data_byte, 8'h00};
            o_grp.pad  = PAD_ONE;
        end else begin
            o_grp.bits = {i_data_byte, 16'h0000};
            o_grp.pad  = PAD_TWO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= 2'd0;
            r_held[0] <= '0;
            r_held[1] <= '0;
        end else if (accept) begin
            if (complete) begin
                r_fill    <= 2'd0;
                r_held[0] <= '0;
                r_held[1] <= '0;
            end else begin
                r_held[r_fill[0]] <= i_data_byte;
                r_fill            <= r_fill + 2'd1;
            end
        end
    end

    `ASSERT_NEVER(a_fill_range, i_clk, i_rst_n, r_fill == 2'd3, "fill count reached three")
    `ASSERT_ALWAYS(a_push_on_final, i_clk, i_rst_n, (accept && i_last_byte) |-> o_grp_push, "final byte did not emit a group")
    `ASSERT_ALWAYS(a_fill_clears, i_clk, i_rst_n, o_grp_push |=> (r_fill == 2'd0), "fill not cleared after group")

endmodule

`default_nettype wire

// ----- hdl/b64e_gq.sv -----
// ----------------------------------------------------------------------------
// b64e_gq
// two-entry group queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module b64e_gq (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    input  wire b64e_pkg::t_group       i_grp,
    input  wire logic                   i_pop,
    output logic                        o_full,
    output logic                        o_valid,
    output b64e_pkg::t_group            o_grp
);
    import b64e_pkg::*;

    t_group     r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full  = r_cnt[1];
    assign o_valid = (r_cnt != 2'd0);
    assign o_grp   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_grp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    `ASSERT_NEVER(a_cnt_range, i_clk, i_rst_n, r_cnt == 2'd3, "queue count overflow")
    `ASSERT_NEVER(a_push_full, i_clk, i_rst_n, i_push && o_full, "group pushed into full queue")
    `ASSERT_ALWAYS(a_ptr_cnt, i_clk, i_rst_n, (r_cnt == 2'd1) == (r_wp != r_rp), "pointers disagree with count")

endmodule

`default_nettype wire

// ----- hdl/b64e_back.sv -----
// ----------------------------------------------------------------------------
// b64e_back
// walks groups one character a cycle into the output register unless stalled
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module b64e_back (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_q_valid,
    input  wire b64e_pkg::t_group       i_grp,
    input  wire logic                   i_pop,
    output logic                        o_q_pop,
    output logic                        o_empty,
    output logic [6:0]                  o_out_char,
    output logic                        o_last_char
);
    import b64e_pkg::*;

    t_group              r_grp;
    logic                r_busy;
    logic [1:0]          r_idx;
    logic                r_valid;
    logic [CHAR_W-1:0]   r_char;
    logic                r_last;
    logic                adv;
    logic                emit;
    logic                take;
    logic [SLICE_W-1:0]  slice;
    logic                is_pad;
    logic [CHAR_W-1:0]   n_char;

    assign adv     = !r_valid || i_pop;
    assign emit    = r_busy && adv;
    // reload as the fourth character leaves so groups run without a gap
    assign take    = i_q_valid && (!r_busy || (emit && r_idx == 2'd3));
    assign o_q_pop = take;

    always_comb begin
        unique case (r_idx)
            2'd0: slice = r_grp.bits[23:18];
            2'd1: slice = r_grp.bits[17:12];
            2'd2: slice = r_grp.bits[11:6];
            2'd3: slice = r_grp.bits[5:0];
        endcase
        is_pad = (r_grp.pad == PAD_TWO && r_idx[1]) ||
                 (r_grp.pad == PAD_ONE && r_idx == 2'd3);
        n_char = is_pad ? PAD_CHAR : b64_char(slice);
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_grp <= i_grp;
        end
        if (emit) begin
            r_char <= n_char;
            r_last <= r_grp.fin && (r_idx == 2'd3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_valid <= 1'b1;
                r_idx   <= r_idx + 2'd1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
            if (take) begin
                r_busy <= 1'b1;
            end else if (emit && r_idx == 2'd3) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_empty     = !r_valid;
    assign o_out_char  = r_char;
    assign o_last_char = r_last;

    `ASSERT_ALWAYS(a_idle_idx, i_clk, i_rst_n, !r_busy |-> (r_idx == 2'd0), "index moved while idle")
    `ASSERT_ALWAYS(a_take_busy, i_clk, i_rst_n, take |=> r_busy, "group taken but unit idle")
    `ASSERT_ALWAYS(a_out_hold, i_clk, i_rst_n, (r_valid && !i_pop) |=> (r_valid && $stable(r_char) && $stable(r_last)), "output beat changed while stalled")

endmodule

`default_nettype wire

// ----- hdl/base64_byte_stream_encoder.sv -----
// ----------------------------------------------------------------------------
// base64_byte_stream_encoder
// streaming base64 encoder, standard alphabet with '=' padding
// ----------------------------------------------------------------------------
// usage:
//   input side is a queue write port: a byte beat is taken on a rising edge
//   with push high and full low; i_last_byte marks the final byte of a message
//   output side is a queue read port: while empty is low the oldest character
//   sits on o_out_char / o_last_char and leaves on an edge with pop high
// path: the group that a beat completes (third byte or final byte) goes into
//   the group queue, then the character unit, then the output register
// throughput: one byte beat per cycle is taken while the group queue has
//   room; the character unit gives one character per cycle while the reader
//   does not stall, so the sustained rate is four characters per three bytes
// stalls: a stalled reader holds the output register; the character unit
//   then stops, the two-entry group queue fills and full rises
// reset: synchronous, active low; clears the partial group, the queue and
//   the output register, so the next byte starts a new message
// ----------------------------------------------------------------------------
`default_nettype none

module base64_byte_stream_encoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // byte beats in
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_byte,
    // character beats out
    output logic            empty,
    input  wire logic       pop,
    output logic [6:0]      o_out_char,
    output logic            o_last_char
);
    import b64e_pkg::*;

    // front to queue
    t_group f_grp;
    logic   f_push;
    logic   q_full;
    // queue to back
    t_group q_grp;
    logic   q_valid;
    logic   q_pop;

    // front: packs bytes into 24-bit groups and tags padding / end of message
    b64e_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_q_full    (q_full),
        .o_full      (full),
        .o_grp_push  (f_push),
        .o_grp       (f_grp)
    );

    // short queue so the front keeps taking bytes while characters drain
    b64e_gq u_gq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_grp   (f_grp),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_grp   (q_grp)
    );

    // back: one character per cycle, unless stalled, into the output register
    b64e_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_grp       (q_grp),
        .i_pop       (pop),
        .o_q_pop     (q_pop),
        .o_empty     (empty),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char)
    );

endmodule

`default_nettype wire

// ----- verif/b64_stream_checker.sv -----
// ----------------------------------------------------------------------------
// b64_stream_checker
// watches the byte and character channels of the base64 stream encoder,
// predicts the characters of every accepted byte beat and compares them,
// in order, with the character beats the encoder gives out
// ----------------------------------------------------------------------------
`default_nettype none

module b64_stream_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_push,
    input  wire logic                        i_full,
    input  wire logic [b64e_pkg::BYTE_W-1:0] i_data_byte,
    input  wire logic                        i_last_byte,
    input  wire logic                        i_empty,
    input  wire logic                        i_pop,
    input  wire logic [b64e_pkg::CHAR_W-1:0] i_out_char,
    input  wire logic                        i_last_char,
    output int                               o_errors,
    output int                               o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    import b64e_pkg::*;

    localparam logic [8*64-1:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              fin;
    } t_char_beat;

    logic [BYTE_W-1:0] held_q [2];
    logic [1:0]        held_cnt;
    t_char_beat        char_fifo [$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    function automatic logic [CHAR_W-1:0] sextet_char(input logic [SLICE_W-1:0] v);
        logic [7:0] c;
        c = ALPHABET[8*(63 - int'(v)) +: 8];
        return c[CHAR_W-1:0];
    endfunction

    // one byte beat: hold it, or close the group and queue four characters
    task automatic encode_beat(input logic [BYTE_W-1:0] b, input logic fin);
        logic [GROUP_W-1:0] grp;
        int                 n_data;
        t_char_beat         cb;
        if (held_cnt >= 2'd2) begin
            grp    = {held_q[0], held_q[1], b};
            n_data = 4;
        end else if (fin) begin
            if (held_cnt == 2'd1) begin
                grp    = {held_q[0], b, 8'h00};
                n_data = 3;
            end else begin
                grp    = {b, 16'h0000};
                n_data = 2;
            end
        end else begin
            held_q[held_cnt[0]] = b;
            held_cnt            = held_cnt + 2'd1;
            return;
        end
        for (int k = 0; k < 4; k++) begin
            cb.ch  = (k < n_data) ? sextet_char(grp[18 - 6*k +: 6]) : PAD_CHAR;
            cb.fin = fin && (k == 3);
            char_fifo.push_back(cb);
        end
        held_q[0] = '0;
        held_q[1] = '0;
        held_cnt  = 2'd0;
    endtask

    always @(posedge i_clk) begin
        t_char_beat exp_beat;
        if (!i_rst_n) begin
            held_q[0] = '0;
            held_q[1] = '0;
            held_cnt  = 2'd0;
            char_fifo.delete();
        end else begin
            // character beat first: it can never belong to a byte taken this edge
            if (i_pop && !i_empty) begin
                if (char_fifo.size() == 0) begin
                    $display("%0t: character beat with nothing expected, actual char %h last %b",
                             $time, i_out_char, i_last_char);
                    o_errors = o_errors + 1;
                end else begin
                    exp_beat = char_fifo.pop_front();
                    if (i_out_char !== exp_beat.ch) begin
                        $display("%0t: out_char expected %h actual %h",
                                 $time, exp_beat.ch, i_out_char);
                        o_errors = o_errors + 1;
                    end
                    if (i_last_char !== exp_beat.fin) begin
                        $display("%0t: last_char expected %b actual %b",
                                 $time, exp_beat.fin, i_last_char);
                        o_errors = o_errors + 1;
                    end
                end
            end
            if (i_push && !i_full) begin
                encode_beat(i_data_byte, i_last_byte);
            end
        end
        o_pending = char_fifo.size();
    end

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the base64 stream encoder: directed messages that
// hit every padding case and the alphabet ends, then random messages, with
// random idling on both the byte side and the character side
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import b64e_pkg::*;

    // random byte beats after the directed messages
    localparam int RANDOM_BYTES = 88;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              push        = 1'b0;
    logic [BYTE_W-1:0] i_data_byte = '0;
    logic              i_last_byte = 1'b0;
    logic              pop         = 1'b0;
    logic              full;
    logic              empty;
    logic [CHAR_W-1:0] o_out_char;
    logic              o_last_char;

    int err_count;
    int pend_count;

    // 12 ns clock period
    always #6 i_clk = ~i_clk;

    base64_byte_stream_encoder uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .empty       (empty),
        .pop         (pop),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char)
    );

    b64_stream_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_full      (full),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_empty     (empty),
        .i_pop       (pop),
        .i_out_char  (o_out_char),
        .i_last_char (o_last_char),
        .o_errors    (err_count),
        .o_pending   (pend_count)
    );

    // idle length: mostly none or short, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // present one byte beat and hold it until the encoder takes it;
    // push is left high so back-to-back beats never toggle it in one step
    task automatic send_beat(input logic [BYTE_W-1:0] b, input logic fin);
        push        <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= fin;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task automatic sender_idle(input int n);
        if (n > 0) begin
            push <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // message of len bytes (1..8), first byte in the highest used lane
    task automatic send_msg(input logic [63:0] bytes, input int len);
        for (int i = 0; i < len; i++) begin
            send_beat(bytes[8*(len-1-i) +: 8], i == len - 1);
            sender_idle(idle_len());
        end
    endtask

    // hold the byte side until every predicted character has come out
    task automatic drain_chars();
        push <= 1'b0;
        @(posedge i_clk);
        wait (pend_count == 0);
        @(posedge i_clk);
    endtask

    // reader: bursts of pop, broken by stalls of random length;
    // some bursts are long so there are stretches with no stall at all
    initial begin
        int burst;
        int stall;
        forever begin
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 12);
            pop <= 1'b1;
            repeat (burst) @(posedge i_clk);
            stall = idle_len();
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    // watchdog
    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int sent;
        int len;
        logic [63:0] bytes;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single byte, both extremes: two characters and double padding
        send_msg(64'h00, 1);
        send_msg(64'hFF, 1);
        // two bytes: three characters and single padding
        send_msg(64'hFFFF, 2);
        // full groups closed by the final byte: all zeros, all ones and "Man"
        send_msg(64'h000000, 3);
        send_msg(64'hFFFFFF, 3);
        send_msg(64'h4D616E, 3);
        // a full group that is not final ('+' chars), then a final full group
        send_msg(64'hFBEFBE_00FF10, 6);
        // a full group then a lone final byte
        send_msg(64'h14FB9C03, 4);

        drain_chars();

        // random messages, mostly short so every padding case comes often
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            len   = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 8)
                                                : $urandom_range(1, 4);
            bytes = {$urandom(), $urandom()};
            send_msg(bytes, len);
            sent = sent + len;
            // one full pause about halfway through
            if (sent >= RANDOM_BYTES / 2 && sent - len < RANDOM_BYTES / 2) begin
                drain_chars();
            end
        end

        // all beats in: let the encoder empty out and idle before the verdict
        drain_chars();
        repeat (10) @(posedge i_clk);

        if (err_count == 0 && pend_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- base64_byte_stream_encoder.f -----
+incdir+hdl
hdl/b64e_pkg.sv
hdl/b64e_front.sv
hdl/b64e_gq.sv
hdl/b64e_back.sv
hdl/base64_byte_stream_encoder.sv
verif/b64_stream_checker.sv
verif/tb_top.sv
